@@ rtl/core/hbtb_pkg.sv @@
// Shared types and constants for the height band texture blender.
package hbtb_pkg;

    localparam int HEIGHT_W   = 16;
    localparam int COLOR_W    = 24;
    localparam int CHAN_W     = 8;
    localparam int RECIP_W    = 24;
    localparam int CNT_W      = 3;
    localparam int FRAC_BITS  = 20;
    localparam int NUM_COLORS = 4;
    localparam int WEIGHT_W   = HEIGHT_W + RECIP_W;
    localparam int PROD_W     = WEIGHT_W + CHAN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TILE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_RECIP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_RECIP = 2'd3;

    localparam logic [CNT_W-1:0]    RST_TILE_COUNT = 3'd1;
    localparam logic [HEIGHT_W-1:0] RST_BAND_WIDTH = 16'd4096;
    localparam logic [RECIP_W-1:0]  RST_RISE_RECIP = 24'd4096;
    localparam logic [RECIP_W-1:0]  RST_FALL_RECIP = 24'd4096;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic [COLOR_W-1:0]  tile0_color;
        logic [COLOR_W-1:0]  tile1_color;
        logic [COLOR_W-1:0]  tile2_color;
        logic [COLOR_W-1:0]  tile3_color;
    } t_pixel_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel_out;

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

@@ rtl/core/height_band_texture_blend.sv @@
// Top level of the height band texture blender: config, lanes, merge, flow control.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------
//  pixel   | in        | i_in_valid / o_in_ready   | i_in_data  (t_pixel_in)
//  blend   | out       | o_out_valid / i_out_ready | o_out_data (t_pixel_out)
//  config  | in        | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One pixel per cycle sustained while the output is not stalled; each pixel passes
// tent select, slope multiply, color multiply and lane sum on its way to output valid.
// Each stage has its own valid bit and loads when it is empty or its own pixel
// moves on, so a stalled output still lets earlier stages fill.
// Synchronous active-low reset clears the valid bits and loads the register
// defaults; payload registers are not reset.
module height_band_texture_blend #(
    parameter int MAX_TILES = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  hbtb_pkg::t_pixel_in               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output hbtb_pkg::t_pixel_out              o_out_data,
    input  logic                              i_cfg_we,
    input  logic [hbtb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [hbtb_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hbtb_pkg::*;

    logic [CNT_W-1:0]    r_tile_count;
    logic [HEIGHT_W-1:0] r_band_width;
    logic [RECIP_W-1:0]  r_rise_recip;
    logic [RECIP_W-1:0]  r_fall_recip;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    t_stage_en en;

    logic [NUM_COLORS-1:0][COLOR_W-1:0] colors;
    logic [MAX_TILES-1:0][PROD_W-1:0]   lane_r;
    logic [MAX_TILES-1:0][PROD_W-1:0]   lane_g;
    logic [MAX_TILES-1:0][PROD_W-1:0]   lane_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_count <= RST_TILE_COUNT;
            r_band_width <= RST_BAND_WIDTH;
            r_rise_recip <= RST_RISE_RECIP;
            r_fall_recip <= RST_FALL_RECIP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TILE_COUNT: r_tile_count <= i_cfg_data[CNT_W-1:0];
                REG_BAND_WIDTH: r_band_width <= i_cfg_data[HEIGHT_W-1:0];
                REG_RISE_RECIP: r_rise_recip <= i_cfg_data[RECIP_W-1:0];
                REG_FALL_RECIP: r_fall_recip <= i_cfg_data[RECIP_W-1:0];
            endcase
        end
    end

    always_comb begin
        en.s4 = !r_v4 || i_out_ready;
        en.s3 = !r_v3 || en.s4;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign o_in_ready  = en.s1;
    assign o_out_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en.s1) r_v1 <= i_in_valid;
            if (en.s2) r_v2 <= r_v1;
            if (en.s3) r_v3 <= r_v2;
            if (en.s4) r_v4 <= r_v3;
        end
    end

    assign colors = {i_in_data.tile3_color, i_in_data.tile2_color,
                     i_in_data.tile1_color, i_in_data.tile0_color};

    for (genvar g = 0; g < MAX_TILES; g++) begin : g_lane
        logic [COLOR_W-1:0] lane_color;

        // tiles past the texel inputs blend as black
        if (g < NUM_COLORS) begin : g_tex
            assign lane_color = colors[g];
        end else begin : g_black
            assign lane_color = '0;
        end

        hbtb_lane #(
            .LANE (g)
        ) u_lane (
            .i_clk        (i_clk),
            .i_en         (en),
            .i_tile_count (r_tile_count),
            .i_band       (r_band_width),
            .i_rise       (r_rise_recip),
            .i_fall       (r_fall_recip),
            .i_height     (i_in_data.height),
            .i_color      (lane_color),
            .o_red        (lane_r[g]),
            .o_green      (lane_g[g]),
            .o_blue       (lane_b[g])
        );
    end

    hbtb_merge #(
        .LANES (MAX_TILES)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (en.s4),
        .i_red   (lane_r),
        .i_green (lane_g),
        .i_blue  (lane_b),
        .o_pixel (o_out_data)
    );

    // input only backs up when every stage holds a pixel
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4))
        else $error("input blocked with an empty pipeline stage");

    // a pixel in the last stage never disappears without an output transaction
    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && !i_out_ready) |=> r_v4)
        else $error("output pixel dropped while stalled");

    // a pixel that enters an empty pipeline passes every stage and reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !r_v1 && !r_v2 && !r_v3 && !r_v4)
        |=> ##3 r_v4)
        else $error("pixel lost in the pipeline");

endmodule

@@ rtl/core/hbtb_lane.sv @@
// One tile lane: tent weight, slope multiply and per-channel color products.
module hbtb_lane #(
    parameter int LANE = 0
) (
    input  logic                           i_clk,
    input  hbtb_pkg::t_stage_en            i_en,
    input  logic [hbtb_pkg::CNT_W-1:0]     i_tile_count,
    input  logic [hbtb_pkg::HEIGHT_W-1:0]  i_band,
    input  logic [hbtb_pkg::RECIP_W-1:0]   i_rise,
    input  logic [hbtb_pkg::RECIP_W-1:0]   i_fall,
    input  logic [hbtb_pkg::HEIGHT_W-1:0]  i_height,
    input  logic [hbtb_pkg::COLOR_W-1:0]   i_color,
    output logic [hbtb_pkg::PROD_W-1:0]    o_red,
    output logic [hbtb_pkg::PROD_W-1:0]    o_green,
    output logic [hbtb_pkg::PROD_W-1:0]    o_blue
);
    import hbtb_pkg::*;

    // wide enough for (LANE+2)*band
    localparam int SPAN_W = HEIGHT_W + $clog2(LANE + 2);

    logic [SPAN_W-1:0]   band_ext;
    logic [SPAN_W-1:0]   h_ext;
    logic [SPAN_W-1:0]   lo;
    logic [SPAN_W-1:0]   pk_end;
    logic [SPAN_W-1:0]   hi_end;
    logic [SPAN_W-1:0]   diff;
    logic                active;
    logic                in_tent;
    logic                rising;
    logic [HEIGHT_W-1:0] n_diff;
    logic [RECIP_W-1:0]  slope;

    logic [HEIGHT_W-1:0] r_diff;
    logic                r_fall;
    logic [COLOR_W-1:0]  r_color1;
    logic [WEIGHT_W-1:0] r_weight;
    logic [COLOR_W-1:0]  r_color2;
    logic [PROD_W-1:0]   r_red;
    logic [PROD_W-1:0]   r_green;
    logic [PROD_W-1:0]   r_blue;

    // pk_end = peak + 1, hi_end = high + 1; an empty band gives no tent
    always_comb begin
        band_ext = SPAN_W'(i_band);
        h_ext    = SPAN_W'(i_height);
        lo       = band_ext * SPAN_W'(LANE);
        pk_end   = lo + band_ext;
        hi_end   = pk_end + band_ext;
        active   = CNT_W'(LANE) < i_tile_count;
        in_tent  = active && (h_ext >= lo) && (h_ext < hi_end);
        rising   = (h_ext + SPAN_W'(1)) < pk_end;
        diff     = rising ? (h_ext - lo) : (hi_end - SPAN_W'(1) - h_ext);
        n_diff   = in_tent ? diff[HEIGHT_W-1:0] : '0;
        slope    = r_fall ? i_fall : i_rise;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_diff   <= n_diff;
            r_fall   <= !rising;
            r_color1 <= i_color;
        end
        if (i_en.s2) begin
            r_weight <= WEIGHT_W'(r_diff) * WEIGHT_W'(slope);
            r_color2 <= r_color1;
        end
        if (i_en.s3) begin
            r_red   <= PROD_W'(r_weight) * PROD_W'(r_color2[23:16]);
            r_green <= PROD_W'(r_weight) * PROD_W'(r_color2[15:8]);
            r_blue  <= PROD_W'(r_weight) * PROD_W'(r_color2[7:0]);
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

@@ rtl/core/hbtb_merge.sv @@
// Sums the lane products per channel, drops the fraction and saturates.
module hbtb_merge #(
    parameter int LANES = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic [LANES-1:0][hbtb_pkg::PROD_W-1:0] i_red,
    input  logic [LANES-1:0][hbtb_pkg::PROD_W-1:0] i_green,
    input  logic [LANES-1:0][hbtb_pkg::PROD_W-1:0] i_blue,
    output hbtb_pkg::t_pixel_out                   o_pixel
);
    import hbtb_pkg::*;

    localparam int ACC_W = PROD_W + $clog2(LANES + 1);
    localparam int INT_W = ACC_W - FRAC_BITS;

    logic [ACC_W-1:0] acc_r;
    logic [ACC_W-1:0] acc_g;
    logic [ACC_W-1:0] acc_b;
    t_pixel_out       n_pixel;
    t_pixel_out       r_pixel;

    function automatic logic [CHAN_W-1:0] sat_chan(input logic [ACC_W-1:0] acc);
        logic [INT_W-1:0] whole;
        whole = acc[ACC_W-1:FRAC_BITS];
        if (|whole[INT_W-1:CHAN_W]) begin
            return {CHAN_W{1'b1}};
        end
        return whole[CHAN_W-1:0];
    endfunction

    always_comb begin
        acc_r = '0;
        acc_g = '0;
        acc_b = '0;
        for (int k = 0; k < LANES; k++) begin
            acc_r = acc_r + ACC_W'(i_red[k]);
            acc_g = acc_g + ACC_W'(i_green[k]);
            acc_b = acc_b + ACC_W'(i_blue[k]);
        end
        n_pixel.red   = sat_chan(acc_r);
        n_pixel.green = sat_chan(acc_g);
        n_pixel.blue  = sat_chan(acc_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

@@ verif/height_band_texture_blend_tb.sv @@
// Self-checking testbench for the height band texture blender.
`timescale 1ns / 1ps

module height_band_texture_blend_tb;
    import hbtb_pkg::*;

    localparam int MAX_TILES   = 4;
    localparam int LATENCY     = 4;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 1000;
    localparam int RAND_PHASES = 9;
    localparam int RAND_ITEMS  = 147;

    // Holds the expected blended pixels and its own copy of the registers.
    class blend_scoreboard;
        t_pixel_out          blend_q[$];
        logic [CNT_W-1:0]    tile_count;
        logic [HEIGHT_W-1:0] band_width;
        logic [RECIP_W-1:0]  rise_recip;
        logic [RECIP_W-1:0]  fall_recip;
        int                  mismatches;
        int                  checked;

        function new();
            tile_count = RST_TILE_COUNT;
            band_width = RST_BAND_WIDTH;
            rise_recip = RST_RISE_RECIP;
            fall_recip = RST_FALL_RECIP;
            mismatches = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_TILE_COUNT: tile_count = val[CNT_W-1:0];
                REG_BAND_WIDTH: band_width = val[HEIGHT_W-1:0];
                REG_RISE_RECIP: rise_recip = val[RECIP_W-1:0];
                REG_FALL_RECIP: fall_recip = val[RECIP_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CHAN_W-1:0] saturate(longint unsigned acc);
            longint unsigned v;
            v = acc >> FRAC_BITS;
            return (v > 255) ? 8'hFF : v[CHAN_W-1:0];
        endfunction

        function t_pixel_out blend(t_pixel_in p);
            longint              h, band, lo, pk, hi;
            longint unsigned     w, acc_r, acc_g, acc_b;
            logic [COLOR_W-1:0]  color;
            int                  active;
            t_pixel_out          res;
            h      = p.height;
            band   = band_width;
            active = (tile_count > MAX_TILES) ? MAX_TILES : tile_count;
            acc_r  = 0;
            acc_g  = 0;
            acc_b  = 0;
            for (int t = 0; t < active; t++) begin
                case (t)
                    0: color = p.tile0_color;
                    1: color = p.tile1_color;
                    2: color = p.tile2_color;
                    3: color = p.tile3_color;
                    default: color = '0;   // no texel input beyond the fourth tile
                endcase
                lo = t * band;
                pk = lo + band - 1;
                hi = pk + band;
                if (h < lo || h > hi)
                    w = 0;
                else if (h < pk)
                    w = (h - lo) * rise_recip;
                else
                    w = (hi - h) * fall_recip;
                acc_r += w * color[23:16];
                acc_g += w * color[15:8];
                acc_b += w * color[7:0];
            end
            res.red   = saturate(acc_r);
            res.green = saturate(acc_g);
            res.blue  = saturate(acc_b);
            return res;
        endfunction

        function void note_pixel(t_pixel_in p);
            blend_q.push_back(blend(p));
        endfunction

        function void check_blend(t_pixel_out got);
            t_pixel_out want;
            if (blend_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result r=%02h g=%02h b=%02h at %0t",
                             got.red, got.green, got.blue, $realtime);
                mismatches++;
                return;
            end
            want = blend_q.pop_front();
            checked++;
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
                if (mismatches < 10)
                    $display({"mismatch on result %0d: expected r=%02h g=%02h b=%02h, ",
                              "got r=%02h g=%02h b=%02h"},
                             checked, want.red, want.green, want.blue,
                             got.red, got.green, got.blue);
                mismatches++;
            end
        endfunction

        function int pending();
            return blend_q.size();
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_pixel_in             i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_pixel_out            o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = REG_TILE_COUNT;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    blend_scoreboard sb = new();

    bit in_gaps_on    = 1'b1;
    bit out_stalls_on = 1'b1;
    bit hold_request  = 1'b0;
    int pixels_sent   = 0;
    int settings_used = 1;
    int holds_done    = 0;
    int idle_cycles   = 0;

    height_band_texture_blend #(
        .MAX_TILES(MAX_TILES)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready)
            sb.note_pixel(i_in_data);
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_blend(o_out_data);
    end

    // Watchdog: cycles without any transaction or register write.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid === 1'b1 && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Output side: random stalls per result, one long hold on request.
    initial begin : drain
        int stall;
        forever begin
            stall = out_stalls_on ? $urandom_range(0, 3) : 0;
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = HOLD_CYCLES;
                holds_done++;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    function automatic t_pixel_in mk_pixel(logic [HEIGHT_W-1:0] h, logic [COLOR_W-1:0] c0,
                                           logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2,
                                           logic [COLOR_W-1:0] c3);
        t_pixel_in p;
        p.height      = h;
        p.tile0_color = c0;
        p.tile1_color = c1;
        p.tile2_color = c2;
        p.tile3_color = c3;
        return p;
    endfunction

    function automatic logic [RECIP_W-1:0] slope_of(int unsigned span);
        longint unsigned q;
        if (span == 0)
            return '1;
        q = (64'd1 << FRAC_BITS) / span;
        return (q > 64'hFF_FFFF) ? '1 : q[RECIP_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] rand_color();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    // Heights mostly inside the active tents, some on tent edges, some anywhere.
    function automatic logic [HEIGHT_W-1:0] rand_height();
        int unsigned     active, band, k, sel;
        longint unsigned span, base;
        active = (sb.tile_count > MAX_TILES) ? MAX_TILES : sb.tile_count;
        band   = sb.band_width;
        sel    = $urandom_range(0, 9);
        if (sel < 2)
            return HEIGHT_W'($urandom);
        if (sel < 4) begin
            k    = (active > 0) ? $urandom_range(0, active - 1) : 0;
            base = k * band;
            case ($urandom_range(0, 4))
                0:       return HEIGHT_W'(base);
                1:       return HEIGHT_W'(base + band - 2);
                2:       return HEIGHT_W'(base + band - 1);
                3:       return HEIGHT_W'(base + 2 * band - 1);
                default: return HEIGHT_W'(base + 2 * band);
            endcase
        end
        span = (active + 1) * band;
        if (span > 65535)
            span = 65535;
        return HEIGHT_W'($urandom_range(0, span));
    endfunction

    task automatic send_pixel(t_pixel_in p);
        int gap;
        gap = in_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        do @(posedge i_clk); while (!o_in_ready);
        pixels_sent++;
    endtask

    // drop valid and wait on the clock first so the last accepted pixel is already queued
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic set_config(logic [CNT_W-1:0] tc, logic [HEIGHT_W-1:0] band,
                              logic [RECIP_W-1:0] rise, logic [RECIP_W-1:0] fall);
        wait_drained();
        write_reg(REG_TILE_COUNT, CFG_DATA_W'(tc));
        write_reg(REG_BAND_WIDTH, CFG_DATA_W'(band));
        write_reg(REG_RISE_RECIP, rise);
        write_reg(REG_FALL_RECIP, fall);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_config();
        logic [CNT_W-1:0]    tc;
        logic [HEIGHT_W-1:0] band;
        logic [RECIP_W-1:0]  rise, fall;
        tc = CNT_W'(($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0:       band = HEIGHT_W'($urandom_range(1, 64));
            1:       band = HEIGHT_W'($urandom_range(65, 4096));
            2:       band = HEIGHT_W'(65536 / ((tc > 0 && tc <= MAX_TILES) ? tc + 1 : 5));
            3:       band = HEIGHT_W'($urandom);
            default: band = HEIGHT_W'($urandom_range(1, 16384));
        endcase
        if ($urandom_range(0, 9) < 8) begin
            rise = slope_of(band - 1);
            fall = slope_of(band);
        end else begin
            rise = RECIP_W'($urandom);
            fall = RECIP_W'($urandom);
        end
        set_config(tc, band, rise, fall);
    endtask

    initial begin : stimulus
        int leftover;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: one tile, tent 0..8191 with peak at 4095.
        send_pixel(mk_pixel(16'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(mk_pixel(16'd4094, 24'h0F0F0F, 24'hFFFFFF, 24'h0, 24'h0));
        send_pixel(mk_pixel(16'd4095, 24'h010203, 24'h0, 24'h0, 24'h0));
        send_pixel(mk_pixel(16'd8191, 24'hFFFFFF, 24'h0, 24'h0, 24'h0));
        send_pixel(mk_pixel(16'd8192, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0));
        send_pixel(mk_pixel(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));

        // Four tiles spanning the height range with matched slopes.
        set_config(3'd4, 16'd16384, slope_of(16383), slope_of(16384));
        send_pixel(mk_pixel(16'd16383, 24'hFFFFFF, 24'h808080, 24'h0, 24'h0));
        send_pixel(mk_pixel(16'd16384, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h0));
        send_pixel(mk_pixel(16'd32766, 24'h123456, 24'hABCDEF, 24'hFFFFFF, 24'h0));
        send_pixel(mk_pixel(16'd32767, 24'h0, 24'hFFFFFF, 24'hFFFFFF, 24'h0));
        send_pixel(mk_pixel(16'd49151, 24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(mk_pixel(16'd65534, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(mk_pixel(16'hFFFF, 24'h0, 24'h0, 24'h0, 24'hFFFFFF));

        // No active tiles: output must be black.
        set_config(3'd0, 16'd16384, slope_of(16383), slope_of(16384));
        send_pixel(mk_pixel(16'd16383, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(mk_pixel(16'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));

        // Count above the tile limit clamps to four.
        set_config(3'd7, 16'd16384, slope_of(16383), slope_of(16384));
        send_pixel(mk_pixel(16'd65534, 24'h0, 24'h0, 24'h0, 24'hFFFFFF));
        send_pixel(mk_pixel(16'd40000, 24'h0, 24'h0, 24'hA5A5A5, 24'h5A5A5A));

        // Empty tents, zero slopes.
        set_config(3'd4, 16'd0, 24'd0, 24'd0);
        send_pixel(mk_pixel(16'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(mk_pixel(16'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));

        // Widest band with maximum slopes: heavy saturation.
        set_config(3'd4, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_pixel(mk_pixel(16'd1, 24'h010101, 24'h0, 24'h0, 24'h0));
        send_pixel(mk_pixel(16'hFFFE, 24'hFFFFFF, 24'hFFFFFF, 24'h0, 24'h0));
        send_pixel(mk_pixel(16'hFFFF, 24'h000001, 24'h010000, 24'h0, 24'h0));

        // One-LSB band: peak coincides with the tent start.
        set_config(3'd4, 16'd1, 24'hFFFFFF, slope_of(1));
        send_pixel(mk_pixel(16'd2, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
        send_pixel(mk_pixel(16'd3, 24'h804020, 24'h102040, 24'h204080, 24'h408010));

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            random_config();
            in_gaps_on    = (ph % 3) != 2;
            out_stalls_on = (ph % 4) != 3;
            if (ph == 4)
                hold_request = 1'b1;   // long output hold while inputs keep coming
            for (int n = 0; n < RAND_ITEMS; n++)
                send_pixel(mk_pixel(rand_height(), rand_color(), rand_color(),
                                    rand_color(), rand_color()));
        end

        wait_drained();
        leftover = sb.pending();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);

        $display("Summary: %0d pixels blended under %0d register settings, %0d results checked",
                 pixels_sent, settings_used, sb.checked);
        $display("Summary: %0d long output holds, %0d mismatches", holds_done, sb.mismatches);
        if (sb.mismatches == 0 && leftover == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
